>>> hdl/gqmv_pkg.sv
// Shared types, constants and codes of the group-quantized int8 matrix-vector unit.
// Depends on nothing; gqmv_lanes, gqmv_merge and the top level import it.
package gqmv_pkg;

  localparam int unsigned LANES       = 8;
  localparam int unsigned LOG_LANES   = 3;
  localparam int unsigned GROUP       = 64;
  localparam int unsigned LOG_GROUP   = 6;
  localparam int unsigned MAX_LEN_DEF = 1024;

  localparam int unsigned LANE_W  = 8;
  localparam int unsigned PROD_W  = 2 * LANE_W;
  localparam int unsigned DOT_W   = PROD_W + LOG_LANES;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned Q_SHIFT = 24;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned VLEN_W  = 11;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd768;

  localparam int unsigned CHUNK_W  = LANES * LANE_W;
  localparam int unsigned IN_DATA_W  = CHUNK_W + SCALE_W;
  localparam int unsigned OUT_DATA_W = TOTAL_W + INDEX_W;

  typedef logic [LANES-1:0][LANE_W-1:0] chunk_t;
  typedef logic [LANES-1:0][PROD_W-1:0] prods_t;

  typedef enum logic {
    FUNC_ACT    = 1'b0,
    FUNC_WEIGHT = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LANE,
    S_MERGE,
    S_TERM,
    S_ACC
  } state_e;

endpackage

>>> hdl/gqmv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the vector store and the activation scales.
module gqmv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/gqmv_lanes.sv
// Parallel int8 multiplier lanes, one registered product per element of a chunk.
// Depends on gqmv_pkg.
module gqmv_lanes (
  input  logic            clk_i,
  input  logic            en_i,
  input  gqmv_pkg::chunk_t act_i,
  input  gqmv_pkg::chunk_t wgt_i,
  output gqmv_pkg::prods_t prods_o
);
  import gqmv_pkg::*;

  prods_t prods_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < LANES; k++) begin
        prods_q[k] <= PROD_W'($signed(act_i[k]) * $signed(wgt_i[k]));
      end
    end
  end

  assign prods_o = prods_q;

endmodule

>>> hdl/gqmv_merge.sv
// Merging stage: adds the lane products of one chunk into a signed dot sum.
// Depends on gqmv_pkg.
module gqmv_merge (
  input  gqmv_pkg::prods_t       prods_i,
  output logic [gqmv_pkg::DOT_W-1:0] dot_o
);
  import gqmv_pkg::*;

  logic [DOT_W-1:0] ext [LANES];
  logic [DOT_W-1:0] sum;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ext[k] = {{(DOT_W-PROD_W){prods_i[k][PROD_W-1]}}, prods_i[k]};
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < LANES; k++) begin
      sum = sum + ext[k];
    end
  end

  assign dot_o = sum;

endmodule

>>> hdl/group_quantized_int8_matvec_unit.sv
// Top level of the group-quantized (q8_0) int8 matrix-vector unit.
// Depends on gqmv_pkg, gqmv_ram, gqmv_lanes and gqmv_merge.
//
// Usage. The slave stream carries chunks of eight int8 elements in tdata
// (lane0 in the lowest byte) with a Q8.24 group scale above them; tuser says
// whether a beat is an activation chunk (0) or a weight chunk of the current
// row (1). Activation beats fill the vector store and, on the first chunk of
// each group of 64, the activation scale; a beat at load position zero starts
// a new vector and restarts the row count. Weight beats stream one row at a
// time against the stored vector. After the last chunk of a row the master
// stream presents one beat with the saturated Q40.24 row total and the row
// index. The effective length is vector_length clamped to 64..MAX_LEN and
// rounded down to a whole number of groups; it is written through cfg_we_i.
//
// Timing. Activation beats are taken back to back while no weight beat is in
// flight. A weight beat passes memory read, lane multiply and merge, and, when
// it closes a group, the term and accumulate steps, as the scale product and
// the group term pass through the two 32 by 32 multipliers one after the other;
// no new beat is taken meanwhile. A row's result is registered in the accumulate
// step of its last beat. Reset clears all control state and sets vector_length
// to 768; the stores are not cleared and need no clearing pass. A stalled result
// stays in the output register; the next weight beat is still taken, and only
// the next row end waits until that result has been taken.
module group_quantized_int8_matvec_unit #(
  parameter int unsigned MAX_LEN = gqmv_pkg::MAX_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: vector_length.
  input  logic                                cfg_we_i,
  input  logic [gqmv_pkg::VLEN_W-1:0]         cfg_wdata_i,
  // Slave stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0 up: lane0..lane7 (8 bits each), group_scale (32 bits).
  input  logic [gqmv_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: func (1 bit).
  input  logic                                s_axis_tuser,
  // Master stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0 up: row_total (64 bits), row_index (16 bits).
  output logic [gqmv_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import gqmv_pkg::*;

  // Position and address widths all follow from MAX_LEN, which must be a
  // multiple of the group size.
  localparam int unsigned POS_W   = $clog2(MAX_LEN);
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned CL_W    = (VLEN_W > LEN_W) ? VLEN_W : LEN_W;
  localparam int unsigned WORDS   = MAX_LEN / LANES;
  localparam int unsigned NGROUPS = MAX_LEN / GROUP;
  localparam int unsigned WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SA_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int unsigned SPROD_W = 2 * SCALE_W;
  localparam int unsigned SHR_W   = SPROD_W - Q_SHIFT;

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [VLEN_W-1:0]     vlen_q;
  logic [POS_W-1:0]      load_pos_q;
  logic [POS_W-1:0]      weight_pos_q;
  logic [SCALE_W-1:0]    wscale_q;
  logic [SCALE_W-1:0]    group_sum_q;
  logic [TOTAL_W-1:0]    acc_q;
  logic [INDEX_W-1:0]    row_cnt_q;
  // Per-beat flags of the weight chunk in flight.
  logic                  first_q, close_q, last_q;
  chunk_t                wgt_q;
  logic [SPROD_W-1:0]    sprod_q;
  logic [SCALE_W-1:0]    sp_q;
  logic [TOTAL_W-1:0]    term_q;
  // Output register.
  logic                  out_valid_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic [INDEX_W-1:0]    out_index_q;

  // ---------------------------------------------------------------------
  // Effective length: clamp to [GROUP, MAX_LEN], then whole groups only.
  // ---------------------------------------------------------------------
  logic [CL_W-1:0] len_clamp;
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    len_clamp = CL_W'(vlen_q);
    if (len_clamp < CL_W'(GROUP)) begin
      len_clamp = CL_W'(GROUP);
    end
    if (len_clamp > CL_W'(MAX_LEN)) begin
      len_clamp = CL_W'(MAX_LEN);
    end
    eff_len = LEN_W'(len_clamp & ~CL_W'(GROUP - 1));
  end

  // ---------------------------------------------------------------------
  // Handshake decode.
  // ---------------------------------------------------------------------
  logic   lane_en;
  logic   act_fire, wgt_fire;
  logic   out_free;
  chunk_t in_chunk;
  logic [SCALE_W-1:0] in_scale;

  assign in_chunk = s_axis_tdata[CHUNK_W-1:0];
  assign in_scale = s_axis_tdata[IN_DATA_W-1:CHUNK_W];
  assign act_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_ACT);
  assign wgt_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_WEIGHT);
  assign out_free = !out_valid_q || m_axis_tready;

  // Next positions of both streams.
  logic [LEN_W-1:0] load_next, weight_next;
  assign load_next   = LEN_W'(load_pos_q) + LEN_W'(LANES);
  assign weight_next = LEN_W'(weight_pos_q) + LEN_W'(LANES);

  // ---------------------------------------------------------------------
  // Stores.
  // ---------------------------------------------------------------------
  logic [CHUNK_W-1:0] act_word;
  logic [SCALE_W-1:0] act_scale;

  gqmv_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (WORDS)
  ) u_vector_store (
    .clk_i   (clk_i),
    .we_i    (act_fire),
    .waddr_i (WA_W'(load_pos_q >> LOG_LANES)),
    .wdata_i (s_axis_tdata[CHUNK_W-1:0]),
    .re_i    (wgt_fire),
    .raddr_i (WA_W'(weight_pos_q >> LOG_LANES)),
    .rdata_o (act_word)
  );

  gqmv_ram #(
    .WIDTH (SCALE_W),
    .DEPTH (NGROUPS)
  ) u_vector_scales (
    .clk_i   (clk_i),
    .we_i    (act_fire && (load_pos_q[LOG_GROUP-1:0] == '0)),
    .waddr_i (SA_W'(load_pos_q >> LOG_GROUP)),
    .wdata_i (in_scale),
    .re_i    (wgt_fire),
    .raddr_i (SA_W'(weight_pos_q >> LOG_GROUP)),
    .rdata_o (act_scale)
  );

  // ---------------------------------------------------------------------
  // Lanes and merge.
  // ---------------------------------------------------------------------
  prods_t           prods;
  logic [DOT_W-1:0] dot;

  gqmv_lanes u_lanes (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .act_i   (act_word),
    .wgt_i   (wgt_q),
    .prods_o (prods)
  );

  gqmv_merge u_merge (
    .prods_i (prods),
    .dot_o   (dot)
  );

  // ---------------------------------------------------------------------
  // Arithmetic between the stages.
  // ---------------------------------------------------------------------
  logic [SCALE_W-1:0] group_sum_d;
  logic [SHR_W-1:0]   sprod_shr;
  logic [SCALE_W-1:0] sp_d;
  logic [TOTAL_W:0]   acc_sum;
  logic [TOTAL_W-1:0] acc_sat;

  always_comb begin
    group_sum_d = (first_q ? '0 : group_sum_q)
                + {{(SCALE_W-DOT_W){dot[DOT_W-1]}}, dot};
  end

  // Arithmetic shift floors towards minus infinity, then saturate to 32 bits.
  always_comb begin
    sprod_shr = sprod_q[SPROD_W-1:Q_SHIFT];
    if (sprod_shr[SHR_W-1] == 1'b0 && sprod_shr[SHR_W-2:SCALE_W-1] != '0) begin
      sp_d = {1'b0, {(SCALE_W-1){1'b1}}};
    end else if (sprod_shr[SHR_W-1] == 1'b1 && sprod_shr[SHR_W-2:SCALE_W-1] != '1) begin
      sp_d = {1'b1, {(SCALE_W-1){1'b0}}};
    end else begin
      sp_d = sprod_shr[SCALE_W-1:0];
    end
  end

  // Saturating 64-bit accumulate: an overflow shows as a mismatch of the
  // two top bits of the widened sum.
  always_comb begin
    acc_sum = {acc_q[TOTAL_W-1], acc_q} + {term_q[TOTAL_W-1], term_q};
    if (acc_sum[TOTAL_W] != acc_sum[TOTAL_W-1]) begin
      acc_sat = acc_sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                 : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[TOTAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (wgt_fire) begin
          state_d = S_LANE;
        end
      end
      S_LANE:  state_d = S_MERGE;
      S_MERGE: state_d = close_q ? S_TERM : S_IDLE;
      S_TERM:  state_d = S_ACC;
      S_ACC: begin
        if (!last_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    lane_en       = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_LANE:  lane_en       = 1'b1;
      S_MERGE, S_TERM, S_ACC: begin
        s_axis_tready = 1'b0;
      end
      default: s_axis_tready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vlen_q       <= VLEN_RESET;
      load_pos_q   <= '0;
      weight_pos_q <= '0;
      wscale_q     <= '0;
      group_sum_q  <= '0;
      acc_q        <= '0;
      row_cnt_q    <= '0;
      first_q      <= 1'b0;
      close_q      <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        vlen_q <= cfg_wdata_i;
      end

      if (act_fire) begin
        // A load at position zero starts a new vector and drops any open row.
        if (load_pos_q == '0) begin
          row_cnt_q    <= '0;
          weight_pos_q <= '0;
          group_sum_q  <= '0;
          acc_q        <= '0;
        end
        load_pos_q <= (load_next >= eff_len) ? '0 : POS_W'(load_next);
      end

      if (wgt_fire) begin
        first_q <= (weight_pos_q[LOG_GROUP-1:0] == '0);
        close_q <= (weight_next[LOG_GROUP-1:0] == '0) || (weight_next >= eff_len);
        last_q  <= (weight_next >= eff_len);
        if (weight_pos_q[LOG_GROUP-1:0] == '0) begin
          wscale_q <= in_scale;
        end
        weight_pos_q <= (weight_next >= eff_len) ? '0 : POS_W'(weight_next);
      end

      if (state_q == S_MERGE) begin
        group_sum_q <= group_sum_d;
      end

      // A row end loads the output register; otherwise a taken result empties it.
      if (state_q == S_ACC && last_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == S_ACC && (!last_q || out_free)) begin
        if (last_q) begin
          row_cnt_q   <= row_cnt_q + INDEX_W'(1);
          acc_q       <= '0;
        end else begin
          acc_q <= acc_sat;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wgt_fire) begin
      wgt_q <= in_chunk;
    end
    if (state_q == S_LANE) begin
      sprod_q <= SPROD_W'($signed(act_scale) * $signed(wscale_q));
    end
    if (state_q == S_MERGE) begin
      sp_q <= sp_d;
    end
    if (state_q == S_TERM) begin
      term_q <= TOTAL_W'($signed(group_sum_q) * $signed(sp_q));
    end
    if (state_q == S_ACC && last_q && out_free) begin
      out_total_q <= acc_sat;
      out_index_q <= row_cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_index_q, out_total_q};

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // Both stream positions stay on chunk boundaries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_pos_q[LOG_LANES-1:0] == '0) && (weight_pos_q[LOG_LANES-1:0] == '0))
    else $error("stream position off a chunk boundary");

  // A weight beat always enters the lane stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wgt_fire |=> (state_q == S_LANE))
    else $error("weight beat did not reach the lanes");

  // A new result only comes from the accumulate step of a row end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_ACC && last_q))
    else $error("result raised outside a row end");

  // A row end never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_total_q) && $stable(out_index_q))
    else $error("waiting result overwritten");

endmodule
